// ----- rtl/uf2bt_pkg.sv -----
package uf2bt_pkg;

	localparam int MAX_BLOCKS_DEF = 256;
	localparam int PAGE_BYTES_DEF = 256;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W = 2;
	localparam int KIND_W = 2;

	// Class a word gets in the front part, before the session state is consulted.
	typedef enum logic [KIND_W-1:0] {
		K_IGNORE = 2'd0,
		K_ERROR  = 2'd1,
		K_CHECK  = 2'd2
	} kind_t;

endpackage

// ----- rtl/uf2_block_tracker.sv -----
// A word accepted at the input passes through the front register, the queue, the
// seen-map read register and the output register, in that order, and waits there
// whenever the output side is not ready.
// Throughput: one word per cycle while the output side is ready and no map sweep runs.
// Reset clears all control state and then sweeps the seen map back to zero;
// the same sweep runs after every 255th completed session.
module uf2_block_tracker #(
	parameter int MAX_BLOCKS = uf2bt_pkg::MAX_BLOCKS_DEF,
	parameter int PAGE_BYTES = uf2bt_pkg::PAGE_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [uf2bt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [31:0]                     magic_first,
	input  logic [31:0]                     magic_second,
	input  logic [31:0]                     block_flags,
	input  logic [31:0]                     flash_addr,
	input  logic [31:0]                     payload_bytes,
	input  logic [31:0]                     block_number,
	input  logic [31:0]                     block_total,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      verdict,
	output logic [31:0]                     program_addr,
	output logic [8:0]                      program_len,
	output logic                            session_done
);
	import uf2bt_pkg::*;

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int Q_W = KIND_W + 32 + 9 + IDX_W + CNT_W;

	logic              f_valid;
	logic              f_ready;
	kind_t             f_kind;
	logic [31:0]       f_addr;
	logic [8:0]        f_len;
	logic [IDX_W-1:0]  f_idx;
	logic [CNT_W-1:0]  f_total;
	logic [Q_W-1:0]    qi_data;
	logic [Q_W-1:0]    qo_data;
	logic              b_valid;
	logic              b_ready;
	logic [KIND_W-1:0] b_kind_raw;
	logic [31:0]       b_addr;
	logic [8:0]        b_len;
	logic [IDX_W-1:0]  b_idx;
	logic [CNT_W-1:0]  b_total;

	assign cfg_ready = 1'b1;

	uf2bt_front #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.PAGE_BYTES(PAGE_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.magic_first(magic_first),
		.magic_second(magic_second),
		.block_flags(block_flags),
		.flash_addr(flash_addr),
		.payload_bytes(payload_bytes),
		.block_number(block_number),
		.block_total(block_total),
		.q_valid(f_valid),
		.q_ready(f_ready),
		.q_kind(f_kind),
		.q_addr(f_addr),
		.q_len(f_len),
		.q_idx(f_idx),
		.q_total(f_total)
	);

	assign qi_data = {f_kind, f_addr, f_len, f_idx, f_total};

	uf2bt_queue #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(f_valid),
		.in_ready(f_ready),
		.in_data(qi_data),
		.out_valid(b_valid),
		.out_ready(b_ready),
		.out_data(qo_data)
	);

	assign {b_kind_raw, b_addr, b_len, b_idx, b_total} = qo_data;

	uf2bt_back #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(b_valid),
		.q_ready(b_ready),
		.q_kind(kind_t'(b_kind_raw)),
		.q_addr(b_addr),
		.q_len(b_len),
		.q_idx(b_idx),
		.q_total(b_total),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.program_addr(program_addr),
		.program_len(program_len),
		.session_done(session_done)
	);

endmodule

// ----- rtl/uf2bt_front.sv -----
module uf2bt_front #(
	parameter int MAX_BLOCKS = uf2bt_pkg::MAX_BLOCKS_DEF,
	parameter int PAGE_BYTES = uf2bt_pkg::PAGE_BYTES_DEF,
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [uf2bt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [31:0]                        magic_first,
	input  logic [31:0]                        magic_second,
	input  logic [31:0]                        block_flags,
	input  logic [31:0]                        flash_addr,
	input  logic [31:0]                        payload_bytes,
	input  logic [31:0]                        block_number,
	input  logic [31:0]                        block_total,
	output logic                               q_valid,
	input  logic                               q_ready,
	output uf2bt_pkg::kind_t                   q_kind,
	output logic [31:0]                        q_addr,
	output logic [8:0]                         q_len,
	output logic [IDX_W-1:0]                   q_idx,
	output logic [CNT_W-1:0]                   q_total
);
	import uf2bt_pkg::*;

	localparam logic [31:0] MAGIC_FIRST = 32'h0A32_4655;
	localparam logic [31:0] MAGIC_SECOND = 32'h9E5D_5157;
	localparam logic [31:0] FW_SIZE_RESET = 32'h0001_0000;
	localparam logic [CFG_IDX_W-1:0] REG_FW_BASE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FW_SIZE = CFG_IDX_W'(1);

	function automatic int trail_zeros(input int v);
		int n;
		n = 0;
		for (int i = 0; i < 31; i++) begin
			if (((v >> i) & 1) == 0 && n == i)
				n = i + 1;
		end
		return n;
	endfunction

	// Inverse of an odd number modulo 2^32 by Newton steps.
	function automatic logic [31:0] odd_inverse(input logic [31:0] m);
		logic [31:0] x;
		x = m;
		for (int i = 0; i < 5; i++)
			x = x * (32'd2 - m * x);
		return x;
	endfunction

	localparam int PAGE_TZ = trail_zeros(PAGE_BYTES);
	localparam logic [31:0] PAGE_ODD = 32'(PAGE_BYTES >> PAGE_TZ);
	localparam logic [31:0] PAGE_INV = odd_inverse(PAGE_ODD);
	localparam logic [31:0] DIV_LIMIT = 32'(64'h0000_0000_FFFF_FFFF / 64'(PAGE_ODD));
	localparam logic [31:0] LOW_MASK = 32'((64'd1 << PAGE_TZ) - 64'd1);
	localparam logic [31:0] PAGE_LIMIT = 32'(PAGE_BYTES);
	localparam logic [31:0] BLOCK_LIMIT = 32'(MAX_BLOCKS);

	logic [31:0]      base_q;
	logic [31:0]      size_q;
	logic             valid_s1;
	logic             ignore_s1;
	logic             err_s1;
	logic [31:0]      prod_s1;
	logic             ge_s1;
	logic [31:0]      diff_s1;
	logic [31:0]      addr_s1;
	logic [8:0]       len_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [CNT_W-1:0] total_s1;
	logic             in_win;
	logic             aligned;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= FW_SIZE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FW_BASE: base_q <= cfg_data;
				REG_FW_SIZE: size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !valid_s1 || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// The odd part of the page size divides the address exactly when the
	// address times its inverse stays at or below the quotient limit.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ignore_s1 <= (magic_first != MAGIC_FIRST) || (magic_second != MAGIC_SECOND)
				|| block_flags[0] || (payload_bytes == 32'd0);
			err_s1 <= (payload_bytes > PAGE_LIMIT) || ((flash_addr & LOW_MASK) != 32'd0)
				|| (block_total > BLOCK_LIMIT) || (block_number >= block_total);
			prod_s1 <= (flash_addr >> PAGE_TZ) * PAGE_INV;
			ge_s1 <= flash_addr >= base_q;
			diff_s1 <= flash_addr - base_q;
			addr_s1 <= flash_addr;
			len_s1 <= payload_bytes[8:0];
			idx_s1 <= block_number[IDX_W-1:0];
			total_s1 <= block_total[CNT_W-1:0];
		end
	end

	assign in_win = ge_s1 && (diff_s1 < size_q);
	assign aligned = prod_s1 <= DIV_LIMIT;

	always_comb begin
		if (ignore_s1)
			q_kind = K_IGNORE;
		else if (err_s1 || !aligned || !in_win)
			q_kind = K_ERROR;
		else
			q_kind = K_CHECK;
	end

	assign q_valid = valid_s1;
	assign q_addr = addr_s1;
	assign q_len = len_s1;
	assign q_idx = idx_s1;
	assign q_total = total_s1;

endmodule

// ----- rtl/uf2bt_queue.sv -----
module uf2bt_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = uf2bt_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready = count_q != CNT_FULL;
	assign out_valid = count_q != '0;
	assign out_data = slot_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_FULL) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(push && pop) |=> $stable(count_q))
		else $error("queue count moved on simultaneous push and pop");

endmodule

// ----- rtl/uf2bt_back.sv -----
module uf2bt_back #(
	parameter int MAX_BLOCKS = uf2bt_pkg::MAX_BLOCKS_DEF,
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  uf2bt_pkg::kind_t q_kind,
	input  logic [31:0]      q_addr,
	input  logic [8:0]       q_len,
	input  logic [IDX_W-1:0] q_idx,
	input  logic [CNT_W-1:0] q_total,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       verdict,
	output logic [31:0]      program_addr,
	output logic [8:0]       program_len,
	output logic             session_done
);
	import uf2bt_pkg::*;

	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_BLOCKS - 1);

	typedef enum logic [1:0] {
		V_IGNORED = 2'd0,
		V_PROGRAM = 2'd1,
		V_REPEAT  = 2'd2,
		V_ERROR   = 2'd3
	} verdict_t;

	// Each entry holds the session tag of the last time its block was seen.
	// Tag zero never matches a live session.
	logic [EPOCH_W-1:0] seen_mem [MAX_BLOCKS];

	logic               b_valid_s1;
	kind_t              kind_s1;
	logic [31:0]        addr_s1;
	logic [8:0]         len_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [CNT_W-1:0]   total_s1;
	logic [EPOCH_W-1:0] tag_s1;
	logic               byp_s1;

	logic               active_q;
	logic [CNT_W-1:0]   expected_q;
	logic [CNT_W-1:0]   count_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               clr_active_q;
	logic [IDX_W-1:0]   clr_idx_q;

	logic               out_valid_q;
	verdict_t           out_verdict_q;
	logic [31:0]        out_addr_q;
	logic [8:0]         out_len_q;
	logic               out_done_q;

	logic               b_fire;
	logic               b_load;
	logic               b_wr;
	logic               start;
	logic               seen;
	logic               accept;
	logic               done;
	logic [EPOCH_W-1:0] epoch_cur;
	logic [CNT_W-1:0]   exp_cur;
	logic [CNT_W-1:0]   cnt_base;
	logic [CNT_W-1:0]   cnt_new;
	verdict_t           verdict_d;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [EPOCH_W-1:0] mem_wdata;

	assign b_fire = b_valid_s1 && !clr_active_q && (!out_valid_q || out_ready);
	assign q_ready = !b_valid_s1 || b_fire;
	assign b_load = q_valid && q_ready;

	assign start = !active_q;
	assign seen = byp_s1 || (tag_s1 == epoch_q);
	assign epoch_cur = start ? epoch_q + EPOCH_W'(1) : epoch_q;
	assign exp_cur = start ? total_s1 : expected_q;
	assign cnt_base = start ? '0 : count_q;
	assign cnt_new = (CNT_W'(idx_s1) < exp_cur) ? cnt_base + CNT_W'(1) : cnt_base;
	assign done = cnt_new >= exp_cur;
	assign accept = (kind_s1 == K_CHECK) && (start || !seen);
	assign b_wr = b_fire && accept;

	always_comb begin
		unique case (kind_s1)
			K_IGNORE: verdict_d = V_IGNORED;
			K_ERROR:  verdict_d = V_ERROR;
			K_CHECK:  verdict_d = accept ? V_PROGRAM : V_REPEAT;
			default:  verdict_d = V_ERROR;
		endcase
	end

	assign mem_we = b_wr || clr_active_q;
	assign mem_waddr = clr_active_q ? clr_idx_q : idx_s1;
	assign mem_wdata = clr_active_q ? '0 : epoch_cur;

	always_ff @(posedge clk) begin
		if (mem_we)
			seen_mem[mem_waddr] <= mem_wdata;
		if (b_load)
			tag_s1 <= seen_mem[q_idx];
	end

	// A write in the cycle a word is loaded misses the registered read.
	always_ff @(posedge clk) begin
		if (b_load) begin
			kind_s1 <= q_kind;
			addr_s1 <= q_addr;
			len_s1 <= q_len;
			idx_s1 <= q_idx;
			total_s1 <= q_total;
			byp_s1 <= b_wr && (idx_s1 == q_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_valid_s1 <= 1'b0;
		end else if (q_ready) begin
			b_valid_s1 <= q_valid;
		end
	end

	// When the session tag runs out, the map is swept back to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			expected_q <= '0;
			count_q <= '0;
			epoch_q <= '0;
			clr_active_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (b_wr) begin
			active_q <= !done;
			expected_q <= exp_cur;
			count_q <= cnt_new;
			if (done && epoch_cur == EPOCH_MAX) begin
				epoch_q <= '0;
				clr_active_q <= 1'b1;
				clr_idx_q <= '0;
			end else begin
				epoch_q <= epoch_cur;
			end
		end else if (clr_active_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == IDX_LAST)
				clr_active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (b_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (b_fire) begin
			out_verdict_q <= verdict_d;
			out_addr_q <= accept ? addr_s1 : '0;
			out_len_q <= accept ? len_s1 : '0;
			out_done_q <= accept && done;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict = out_verdict_q;
	assign program_addr = out_addr_q;
	assign program_len = out_len_q;
	assign session_done = out_done_q;

	a_count_below: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> count_q < expected_q)
		else $error("seen count reached the total in a live session");

	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !b_wr)
		else $error("block write during the map sweep");

	a_done_programs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> out_verdict_q == V_PROGRAM)
		else $error("session done on a word that was not programmed");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(b_wr && done) |=> !active_q)
		else $error("session still active after completion");

endmodule

// ----- bench/uf2bt_tb_pkg.sv -----
package uf2bt_tb_pkg;

	localparam logic [31:0] UF2_MAGIC_FIRST  = 32'h0A32_4655;
	localparam logic [31:0] UF2_MAGIC_SECOND = 32'h9E5D_5157;

	localparam logic [uf2bt_pkg::CFG_IDX_W-1:0] REG_FW_BASE = 'd0;
	localparam logic [uf2bt_pkg::CFG_IDX_W-1:0] REG_FW_SIZE = 'd1;

	typedef enum logic [1:0] {
		VERDICT_IGNORED = 2'd0,
		VERDICT_PROGRAM = 2'd1,
		VERDICT_REPEAT  = 2'd2,
		VERDICT_ERROR   = 2'd3
	} verdict_e;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [31:0] addr;
		logic [8:0]  len;
		logic        done;
	} block_verdict_t;

endpackage

// ----- bench/uf2_block_tracker_checker.sv -----
module uf2_block_tracker_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [uf2bt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [31:0]                     magic_first,
	input  logic [31:0]                     magic_second,
	input  logic [31:0]                     block_flags,
	input  logic [31:0]                     flash_addr,
	input  logic [31:0]                     payload_bytes,
	input  logic [31:0]                     block_number,
	input  logic [31:0]                     block_total,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [1:0]                      verdict,
	input  logic [31:0]                     program_addr,
	input  logic [8:0]                      program_len,
	input  logic                            session_done,
	output int                              fail_count,
	output int                              verdicts_pending
);
	import uf2bt_tb_pkg::*;

	localparam int MAX_BLOCKS = uf2bt_pkg::MAX_BLOCKS_DEF;
	localparam int PAGE_BYTES = uf2bt_pkg::PAGE_BYTES_DEF;

	logic [31:0]    fw_base;
	logic [31:0]    fw_size;
	bit             session_open;
	logic [8:0]     blocks_expected;
	logic [8:0]     blocks_seen;
	bit             seen_map [MAX_BLOCKS];
	block_verdict_t verdicts_due [$];
	block_verdict_t got;
	block_verdict_t want;

	// The window ends at 2^32 rather than wrapping, hence the 33-bit offset.
	function automatic bit in_fw_window(logic [31:0] a);
		logic [32:0] offset;
		if (a < fw_base)
			return 1'b0;
		offset = {1'b0, a} - {1'b0, fw_base};
		return offset < {1'b0, fw_size};
	endfunction

	function automatic block_verdict_t judge_block(
		logic [31:0] m1, logic [31:0] m2, logic [31:0] flags, logic [31:0] addr,
		logic [31:0] len, logic [31:0] num, logic [31:0] total
	);
		block_verdict_t v;
		v.verdict = VERDICT_IGNORED;
		v.addr    = '0;
		v.len     = '0;
		v.done    = 1'b0;
		if (m1 != UF2_MAGIC_FIRST || m2 != UF2_MAGIC_SECOND || flags[0] || len == 0)
			return v;
		v.verdict = VERDICT_ERROR;
		if (len > PAGE_BYTES || (addr % PAGE_BYTES) != 0 || total > MAX_BLOCKS ||
				num >= total || !in_fw_window(addr))
			return v;
		if (!session_open) begin
			session_open    = 1'b1;
			blocks_expected = total[8:0];
			seen_map        = '{default: 1'b0};
			blocks_seen     = '0;
		end else if (seen_map[num]) begin
			v.verdict = VERDICT_REPEAT;
			return v;
		end
		// A block from a file with another total is marked but only counts when
		// its number lies below the latched total.
		seen_map[num] = 1'b1;
		if (num < blocks_expected)
			blocks_seen++;
		if (blocks_seen >= blocks_expected) begin
			v.done       = 1'b1;
			session_open = 1'b0;
		end
		v.verdict = VERDICT_PROGRAM;
		v.addr    = addr;
		v.len     = len[8:0];
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_base          = '0;
			fw_size          = 32'd65536;
			session_open     = 1'b0;
			blocks_expected  = '0;
			blocks_seen      = '0;
			seen_map         = '{default: 1'b0};
			verdicts_due.delete();
			fail_count       = 0;
			verdicts_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FW_BASE: fw_base = cfg_data;
					REG_FW_SIZE: fw_size = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				verdicts_due.push_back(judge_block(magic_first, magic_second, block_flags,
					flash_addr, payload_bytes, block_number, block_total));
			if (out_valid && out_ready) begin
				got.verdict = verdict;
				got.addr    = program_addr;
				got.len     = program_len;
				got.done    = session_done;
				if (verdicts_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("verdict word with nothing outstanding:",
							" v=%0d addr=%h len=%0d done=%b",
							got.verdict, got.addr, got.len, got.done);
				end else begin
					want = verdicts_due.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("verdict mismatch: expected v=%0d addr=%h len=%0d done=%b,",
								want.verdict, want.addr, want.len, want.done,
								" got v=%0d addr=%h len=%0d done=%b",
								got.verdict, got.addr, got.len, got.done);
					end
				end
			end
			verdicts_pending = verdicts_due.size();
		end
	end

endmodule

// ----- bench/tb_uf2_block_tracker.sv -----
module tb_uf2_block_tracker;
	import uf2bt_tb_pkg::*;

	localparam int MAX_BLOCKS   = uf2bt_pkg::MAX_BLOCKS_DEF;
	localparam int PAGE         = uf2bt_pkg::PAGE_BYTES_DEF;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_PHASES   = 7;

	typedef enum int {
		NOISE_MAGIC_FIRST,
		NOISE_MAGIC_SECOND,
		NOISE_NO_FLASH,
		NOISE_EMPTY,
		NOISE_LONG,
		NOISE_UNALIGNED,
		NOISE_TOTAL,
		NOISE_NUMBER,
		NOISE_OUTSIDE
	} noise_e;

	logic                            clk;
	logic                            arst_n        = 1'b0;
	logic                            cfg_valid     = 1'b0;
	logic                            cfg_ready;
	logic [uf2bt_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
	logic [31:0]                     cfg_data      = '0;
	logic                            in_valid      = 1'b0;
	logic                            in_ready;
	logic [31:0]                     magic_first   = '0;
	logic [31:0]                     magic_second  = '0;
	logic [31:0]                     block_flags   = '0;
	logic [31:0]                     flash_addr    = '0;
	logic [31:0]                     payload_bytes = '0;
	logic [31:0]                     block_number  = '0;
	logic [31:0]                     block_total   = '0;
	logic                            out_valid;
	logic                            out_ready     = 1'b0;
	logic [1:0]                      verdict;
	logic [31:0]                     program_addr;
	logic [8:0]                      program_len;
	logic                            session_done;

	int          fail_count;
	int          verdicts_pending;
	int          cycle_count    = 0;
	int          blocks_counted = 0;
	int          burst_left     = 0;
	bit          hold_req       = 1'b0;
	logic [31:0] cur_base       = '0;
	logic [31:0] cur_size       = 32'd65536;

	logic [31:0] phase_base  [NUM_PHASES] = '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
		32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000};
	logic [31:0] phase_size  [NUM_PHASES] = '{32'h0001_0000, 32'h0000_8000, 32'h0000_0000,
		32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
	int          phase_items [NUM_PHASES] = '{340, 340, 40, 340, 40, 340, 340};

	uf2_block_tracker DUT (.*);

	uf2_block_tracker_checker u_verdict_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: ready runs broken by stalls, an occasional steady stretch, and one
	// long hold-off that backs the block up into its input.
	initial begin
		int  stall;
		int  r;
		bit  hold_done;
		hold_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				out_ready <= 1'b1;
				if (r < 5)
					repeat ($urandom_range(100, 300)) @(posedge clk);
				else
					repeat ($urandom_range(1, 8)) @(posedge clk);
				r = $urandom_range(0, 99);
				stall = (r < 75) ? $urandom_range(0, 2) :
					(r < 95) ? $urandom_range(3, 8) : $urandom_range(20, 60);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	task automatic write_reg(input logic [uf2bt_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_FW_BASE)
			cur_base = data;
		else
			cur_size = data;
		@(posedge clk);
	endtask

	// Returns where the word went in with valid high, or after a random gap with valid
	// low; the next word must follow without time passing, or the gap lowers valid.
	task automatic send_block(
		input logic [31:0] m1, input logic [31:0] m2, input logic [31:0] flags,
		input logic [31:0] addr, input logic [31:0] len, input logic [31:0] num,
		input logic [31:0] total
	);
		int gap;
		int r;
		in_valid      <= 1'b1;
		magic_first   <= m1;
		magic_second  <= m2;
		block_flags   <= flags;
		flash_addr    <= addr;
		payload_bytes <= len;
		block_number  <= num;
		block_total   <= total;
		do @(posedge clk); while (!in_ready);
		gap = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3)
				burst_left = $urandom_range(30, 100);
			gap = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// An aligned page address inside the current window, favoring its first and
	// last pages; any aligned address when the window holds no page.
	function automatic logic [31:0] window_addr();
		longint lo;
		longint hi;
		longint pages;
		int     r;
		lo = ((longint'(cur_base) + PAGE - 1) / PAGE) * PAGE;
		hi = longint'(cur_base) + longint'(cur_size);
		if (hi > 64'h1_0000_0000)
			hi = 64'h1_0000_0000;
		if (lo >= hi)
			return $urandom & ~32'(PAGE - 1);
		pages = (hi - 1 - lo) / PAGE;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 32'(lo);
		if (r < 20)
			return 32'(lo + pages * PAGE);
		return 32'(lo + longint'($urandom_range(0, int'(pages))) * PAGE);
	endfunction

	task automatic send_good(input logic [31:0] num, input logic [31:0] total);
		logic [31:0] len;
		int          r;
		r = $urandom_range(0, 99);
		len = (r < 15) ? PAGE : (r < 25) ? 1 : $urandom_range(1, PAGE);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, $urandom & ~32'h1, window_addr(),
			len, num, total);
		blocks_counted++;
	endtask

	task automatic send_noise();
		noise_e      kind;
		logic [31:0] m1, m2, flags, addr, len, num, total;
		kind  = noise_e'($urandom_range(0, NOISE_OUTSIDE));
		m1    = UF2_MAGIC_FIRST;
		m2    = UF2_MAGIC_SECOND;
		flags = $urandom & ~32'h1;
		addr  = window_addr();
		len   = $urandom_range(1, PAGE);
		total = $urandom_range(1, MAX_BLOCKS);
		num   = $urandom_range(0, total - 1);
		case (kind)
			NOISE_MAGIC_FIRST: begin
				m1 = $urandom;
				if (m1 == UF2_MAGIC_FIRST)
					m1 = ~m1;
				num   = $urandom;
				total = $urandom;
			end
			NOISE_MAGIC_SECOND: begin
				m2 = $urandom;
				if (m2 == UF2_MAGIC_SECOND)
					m2 = ~m2;
				num   = $urandom;
				total = $urandom;
			end
			NOISE_NO_FLASH: begin
				flags = $urandom | 32'h1;
				num   = $urandom;
				total = $urandom;
			end
			NOISE_EMPTY: begin
				len   = '0;
				num   = $urandom;
				total = $urandom;
			end
			NOISE_LONG:      len   = $urandom_range(PAGE + 1, 32'hFFFF_FFFF);
			NOISE_UNALIGNED: addr  = addr | $urandom_range(1, PAGE - 1);
			NOISE_TOTAL: begin
				total = $urandom_range(MAX_BLOCKS + 1, 32'hFFFF_FFFF);
				num   = $urandom;
			end
			NOISE_NUMBER:    num   = $urandom_range(total, 32'hFFFF_FFFF);
			default:         addr  = $urandom & ~32'(PAGE - 1);
		endcase
		send_block(m1, m2, flags, addr, len, num, total);
		if (kind >= NOISE_LONG)
			blocks_counted++;
	endtask

	// One file's blocks in shuffled order, salted with repeats, blocks from a file
	// of another size and malformed words. Small files are sometimes cut short so
	// that the next file lands in an open session.
	task automatic run_session(input int total);
		int order [$];
		int count;
		int j;
		int tmp;
		int n;
		for (int k = 0; k < total; k++)
			order.push_back(k);
		for (int k = total - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		count = total;
		if (total <= 48 && $urandom_range(0, 9) == 0)
			count = $urandom_range(1, total);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_noise();
			if (i > 0 && $urandom_range(0, 7) == 0)
				send_good(order[$urandom_range(0, i - 1)], total);
			if ($urandom_range(0, 24) == 0) begin
				n = $urandom_range(0, MAX_BLOCKS - 1);
				send_good(n, $urandom_range(n + 1, MAX_BLOCKS));
			end
			send_good(order[i], total);
		end
	endtask

	function automatic int pick_total();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(1, 4);
		if (r < 85)
			return $urandom_range(5, 16);
		return $urandom_range(17, 48);
	endfunction

	initial begin
		int target;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_FW_BASE, phase_base[0]);
		write_reg(REG_FW_SIZE, phase_size[0]);

		// Directed words against the default window of 64 KiB at address zero.
		send_block(~UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, '0, 16, 0, 1);
		send_block(UF2_MAGIC_FIRST, ~UF2_MAGIC_SECOND, '0, '0, 16, 0, 1);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, 32'h1, '0, 16, 0, 1);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, 32'hFFFF_FFFF, '0, 16, 0, 1);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, '0, 0, 0, 1);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, '0, PAGE + 1, 0, 1);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, '0, 32'hFFFF_FFFF, 0, 1);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, 32'h80, 16, 0, 1);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, '0, 16, 0, MAX_BLOCKS + 1);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, '0, 16, 0, 32'hFFFF_FFFF);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, '0, 16, 4, 4);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, '0, 16, 32'hFFFF_FFFF, MAX_BLOCKS);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, 32'h1_0000, 16, 0, 3);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, 32'hFFFF_FFFE, '0, PAGE, 1, 3);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, 32'h100, 16, 1, 3);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, 32'h200, 32, 7, 10);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, 32'hFFFF_FF00, 16, 0, 3);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, 32'hFF00, 1, 0, 3);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, 32'h300, PAGE, 2, 3);
		send_block(UF2_MAGIC_FIRST, UF2_MAGIC_SECOND, '0, 32'h400, 8, 0, 1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				drain();
				if (p == 5) begin
					// An unaligned base with a modest window somewhere in the space.
					phase_base[p] = $urandom;
					phase_size[p] = $urandom_range(32'h800, 32'h4_0000);
				end
				write_reg(REG_FW_BASE, phase_base[p]);
				write_reg(REG_FW_SIZE, phase_size[p]);
			end
			if (p == 1)
				hold_req = 1'b1;
			target = blocks_counted + phase_items[p];
			if (p == 0)
				run_session(MAX_BLOCKS);
			while (blocks_counted < target)
				run_session(pick_total());
		end

		drain();
		if (fail_count == 0 && verdicts_pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
